[rtl/core/lpv_pkg.sv]
// Shared types and constants of the lidar point validator.
package lpv_pkg;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_POINT  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_STAMP = 2'd1;
    localparam logic [1:0] STATUS_OFFSET    = 2'd2;
    localparam logic [1:0] STATUS_INVALID   = 2'd3;

    localparam logic CFG_TIME_OFFSET = 1'b0;
    localparam logic CFG_MAX_DELTA   = 1'b1;

    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 280;

    typedef struct packed {
        logic        op;
        logic        hdr_bad;
        logic        pt_pre_ok;
        logic [15:0] ring;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] intensity;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] stamp_ns;
        logic [31:0] group_num;
        logic [15:0] ring_out;
        logic [31:0] x_out;
        logic [31:0] y_out;
        logic [31:0] z_out;
        logic [31:0] intensity_out;
        logic [31:0] invalid_count;
    } result_t;

endpackage

[rtl/core/lpv_ns_conv.sv]
// Three-stage conversion of a double time in seconds to rounded nanoseconds.
module lpv_ns_conv
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] time_bits,
    output logic [63:0] ns,
    output logic        ok
);

    logic [10:0] ex;
    logic [51:0] frac;
    logic [52:0] m;
    logic signed [11:0] e;
    logic        bad;

    logic [61:0] a_reg;
    logic [50:0] b_reg;
    logic signed [11:0] e1_reg;
    logic        bad1_reg;

    logic [82:0] q_reg;
    logic signed [11:0] e2_reg;
    logic        bad2_reg;

    logic [63:0] ns_next;
    logic        ok_next;
    logic [63:0] ns_reg;
    logic        ok_reg;

    logic [146:0] wide;
    logic [11:0]  s;
    logic [6:0]   sa;
    logic [82:0]  f;
    logic [82:0]  rbv;
    logic [82:0]  mask;
    logic         sticky;

    always_comb
    begin
        ex   = time_bits[62:52];
        frac = time_bits[51:0];
        bad  = (ex == 11'h7FF) || (time_bits[63] && (ex != 11'd0 || frac != 52'd0));
        if (ex == 11'd0)
        begin
            m = {1'b0, frac};
            e = -12'sd1074;
        end
        else
        begin
            m = {1'b1, frac};
            e = $signed({1'b0, ex}) - 12'sd1075;
        end
        if (time_bits[63])
        begin
            m = 53'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= 62'(m[31:0]) * 62'(lpv_pkg::NS_PER_SEC);
            b_reg    <= 51'(m[52:32]) * 51'(lpv_pkg::NS_PER_SEC);
            e1_reg   <= e;
            bad1_reg <= bad;
            q_reg    <= {21'd0, a_reg} + {b_reg, 32'd0};
            e2_reg   <= e1_reg;
            bad2_reg <= bad1_reg;
            ns_reg   <= ns_next;
            ok_reg   <= ok_next;
        end
    end

    always_comb
    begin
        wide    = {64'd0, q_reg} << e2_reg[5:0];
        s       = 12'(-e2_reg);
        sa      = s[6:0];
        f       = q_reg >> sa;
        rbv     = q_reg >> (sa - 7'd1);
        mask    = (83'd1 << sa) - 83'd1;
        sticky  = |(q_reg & mask);
        ns_next = 64'd0;
        ok_next = 1'b0;
        if (bad2_reg)
        begin
            ok_next = 1'b0;
        end
        else if (!e2_reg[11])
        begin
            if (e2_reg[10:6] == 5'd0 && wide[146:64] == 83'd0)
            begin
                ok_next = 1'b1;
                ns_next = wide[63:0];
            end
        end
        else if (s >= 12'd84)
        begin
            ok_next = 1'b1;
        end
        else
        begin
            ok_next = (f[82:64] == 19'd0) && !((&f[63:0]) && sticky);
            ns_next = f[63:0] + 64'(rbv[0]);
        end
    end

    assign ns = ns_reg;
    assign ok = ok_reg;

endmodule

[rtl/core/lidar_point_validator_core.sv]
// Top level of the lidar point validator: stream pipeline, state and result register.
//
// Channel   Direction  Contents
// s_*       in         header or point request, tuser = op
// m_*       out        one result per request
// cfg_*     in         register writes, index 0 time offset, 1 max delta
//
// Every request passes in order through the input register, the item registers and the result register.
// One request is accepted per cycle; the pipeline moves as one whole.
// It stalls only when the result register is full and not taken.
// Reset clears the valid bits, the configuration and the tracking state.
module lidar_point_validator_core
#(
    parameter int RING_COUNT = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // stamp_sec, stamp_nanosec, ring_index, x_bits, y_bits, z_bits,
    // intensity_bits, time_bits
    input  logic [lpv_pkg::IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, stamp_ns, group_num, ring_out, x_out, y_out, z_out,
    // intensity_out, invalid_count, zero padding
    output logic [lpv_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_wen,
    input  logic                           cfg_index,
    input  logic [63:0]                    cfg_data
);

    logic adv;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic [63:0] offset_reg, max_delta_reg;

    lpv_pkg::item_t it0, it1_reg, it2_reg, it3_reg, it4_reg;
    logic [271:0] in_reg;
    logic [63:0]  time0;
    logic [31:0]  sec0, nsec0;
    logic         op0_reg;
    logic [31:0]  it1_nsec_reg;

    logic [60:0]  hprod_reg;
    logic [63:0]  hraw2_reg, hraw3_reg;

    logic [63:0]  conv_ns;
    logic         conv_ok;

    logic [63:0]  header_ns_reg, header_ns_next;
    logic [63:0]  t3;
    logic [64:0]  sum3, d1, d2;
    logic [63:0]  sum4_reg, dist4_reg;
    logic         off_ok4_reg, pt_ok4_reg;

    logic         have_prev_reg, have_prev_next;
    logic [7:0]   prev_ring_reg, prev_ring_next;
    logic [31:0]  group_reg, group_next, rej_reg, rej_next;
    logic         ring_ok, pt_valid;

    lpv_pkg::result_t res_reg, res_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_reg    <= 64'd0;
            max_delta_reg <= 64'd0;
            header_ns_reg <= 64'd0;
            have_prev_reg <= 1'b0;
            prev_ring_reg <= 8'd0;
            group_reg     <= 32'd0;
            rej_reg       <= 32'd0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    lpv_pkg::CFG_TIME_OFFSET: offset_reg    <= cfg_data;
                    lpv_pkg::CFG_MAX_DELTA:   max_delta_reg <= cfg_data;
                    default:                  offset_reg    <= offset_reg;
                endcase
            end
            if (adv)
            begin
                v0_reg        <= s_tvalid;
                v1_reg        <= v0_reg;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                out_valid_reg <= v4_reg;
                if (v3_reg)
                begin
                    header_ns_reg <= header_ns_next;
                end
                if (v4_reg)
                begin
                    have_prev_reg <= have_prev_next;
                    prev_ring_reg <= prev_ring_next;
                    group_reg     <= group_next;
                    rej_reg       <= rej_next;
                end
            end
        end
    end

    // Input register, item pipeline, header multiply and result register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg    <= s_tdata;
            it1_reg   <= it0;
            it2_reg   <= it1_reg;
            it3_reg   <= it2_reg;
            it4_reg   <= it3_reg;
            hprod_reg <= 61'(sec0[30:0]) * 61'(lpv_pkg::NS_PER_SEC);
            hraw2_reg <= 64'(hprod_reg) + 64'(it1_nsec_reg);
            hraw3_reg <= hraw2_reg;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op0_reg      <= s_tuser;
            it1_nsec_reg <= nsec0;
        end
    end

    always_comb
    begin
        sec0          = in_reg[31:0];
        nsec0         = in_reg[63:32];
        time0         = in_reg[271:208];
        it0.op        = op0_reg;
        it0.hdr_bad   = sec0[31] || (nsec0 >= 32'(lpv_pkg::NS_PER_SEC));
        it0.ring      = in_reg[79:64];
        it0.x         = in_reg[111:80];
        it0.y         = in_reg[143:112];
        it0.z         = in_reg[175:144];
        it0.intensity = in_reg[207:176];
        it0.pt_pre_ok = (it0.ring < 16'(RING_COUNT))
                      && (it0.x[30:23] != 8'hFF) && (it0.y[30:23] != 8'hFF)
                      && (it0.z[30:23] != 8'hFF) && (it0.intensity[30:23] != 8'hFF);
    end

    lpv_ns_conv u_conv
    (
        .clk       (clk),
        .en        (adv),
        .time_bits (time0),
        .ns        (conv_ns),
        .ok        (conv_ok)
    );

    // Header stamp update, offset add and distance terms.
    always_comb
    begin
        header_ns_next = header_ns_reg;
        if (it3_reg.op == lpv_pkg::OP_HEADER)
        begin
            header_ns_next = it3_reg.hdr_bad ? 64'd0 : hraw3_reg;
        end
        t3   = (it3_reg.op == lpv_pkg::OP_POINT) ? conv_ns : hraw3_reg;
        sum3 = {1'b0, t3} + {1'b0, offset_reg};
        d1   = {1'b0, conv_ns} - {1'b0, header_ns_reg};
        d2   = {1'b0, header_ns_reg} - {1'b0, conv_ns};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum4_reg    <= sum3[63:0];
            off_ok4_reg <= offset_reg[63] ? sum3[64] : !sum3[64];
            dist4_reg   <= d1[64] ? d2[63:0] : d1[63:0];
            pt_ok4_reg  <= it3_reg.pt_pre_ok && conv_ok && (conv_ns != 64'd0);
        end
    end

    // Tracking state and result assembly.
    always_comb
    begin
        ring_ok        = it4_reg.ring < 16'(RING_COUNT);
        have_prev_next = have_prev_reg;
        prev_ring_next = prev_ring_reg;
        group_next     = group_reg;
        rej_next       = rej_reg;
        pt_valid       = pt_ok4_reg && (dist4_reg <= max_delta_reg) && off_ok4_reg;
        res_next       = '0;
        if (it4_reg.op == lpv_pkg::OP_HEADER)
        begin
            have_prev_next = 1'b0;
            prev_ring_next = 8'd0;
            group_next     = 32'd0;
            rej_next       = 32'd0;
            if (it4_reg.hdr_bad)
            begin
                res_next.status = lpv_pkg::STATUS_BAD_STAMP;
            end
            else if (!off_ok4_reg)
            begin
                res_next.status = lpv_pkg::STATUS_OFFSET;
            end
            else
            begin
                res_next.status   = lpv_pkg::STATUS_OK;
                res_next.stamp_ns = sum4_reg;
            end
        end
        else
        begin
            if (ring_ok)
            begin
                if (have_prev_reg && (it4_reg.ring <= {8'd0, prev_ring_reg})
                    && (group_reg != 32'hFFFF_FFFF))
                begin
                    group_next = group_reg + 32'd1;
                end
                prev_ring_next = it4_reg.ring[7:0];
                have_prev_next = 1'b1;
            end
            if (!pt_valid)
            begin
                if (rej_reg != 32'hFFFF_FFFF)
                begin
                    rej_next = rej_reg + 32'd1;
                end
                res_next.status = lpv_pkg::STATUS_INVALID;
            end
            else
            begin
                res_next.status   = lpv_pkg::STATUS_OK;
                res_next.stamp_ns = sum4_reg;
            end
            res_next.group_num     = group_next;
            res_next.ring_out      = it4_reg.ring;
            res_next.x_out         = it4_reg.x;
            res_next.y_out         = it4_reg.y;
            res_next.z_out         = it4_reg.z;
            res_next.intensity_out = it4_reg.intensity;
            res_next.invalid_count = rej_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_reg.invalid_count, res_reg.intensity_out, res_reg.z_out,
                       res_reg.y_out, res_reg.x_out, res_reg.ring_out, res_reg.group_num,
                       res_reg.stamp_ns, res_reg.status};

    a_no_stamp_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.status != lpv_pkg::STATUS_OK |-> res_reg.stamp_ns == 64'd0)
        else $error("Stamp given with an error status.");

    a_invalid_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.status == lpv_pkg::STATUS_INVALID
        |-> res_reg.invalid_count != 32'd0)
        else $error("Rejected point not counted.");

    a_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_reg.status == lpv_pkg::STATUS_BAD_STAMP
        |-> res_reg.group_num == 32'd0 && res_reg.invalid_count == 32'd0)
        else $error("Header result carries point tracking.");

endmodule

[dv/lidar_point_validator_core_test.sv]
// Self-checking testbench for the lidar point validator core with a predicting scoreboard.
`timescale 1ns / 1ps

module lidar_point_validator_core_test;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] stamp_ns;
        logic [31:0] group_num;
        logic [15:0] ring_out;
        logic [31:0] x_out;
        logic [31:0] y_out;
        logic [31:0] z_out;
        logic [31:0] intensity_out;
        logic [31:0] invalid_count;
    } point_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lpv_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lpv_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_wen = 1'b0;
    logic                           cfg_index = 1'b0;
    logic [63:0]                    cfg_data = '0;

    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 15;
    int recv_idle_pct = 53;
    int headers_sent = 0;
    int points_sent = 0;
    int results_seen = 0;

    lidar_point_validator_core dut (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    class stamp_scoreboard;
        logic [63:0] offset_ns = '0;
        logic [63:0] max_delta = '0;
        logic [63:0] header_ns = '0;
        bit          have_prev = 1'b0;
        logic [7:0]  prev_ring = '0;
        logic [31:0] group_count = '0;
        logic [31:0] rejected = '0;
        point_result_t pending[$];

        function automatic bit add_offset(input logic [63:0] t, output logic [63:0] res);
            logic [63:0] mag;
            res = '0;
            if (!offset_ns[63]) begin
                if (t > 64'hFFFF_FFFF_FFFF_FFFF - offset_ns) return 1'b0;
                res = t + offset_ns;
                return 1'b1;
            end
            mag = ~offset_ns + 64'd1;
            if (t < mag) return 1'b0;
            res = t - mag;
            return 1'b1;
        endfunction

        function automatic bit seconds_to_ns(input logic [63:0] bits, output logic [63:0] ns);
            logic [10:0]  ex;
            logic [52:0]  m;
            logic [127:0] q;
            logic [191:0] wide;
            logic [127:0] f;
            logic         rb;
            logic [127:0] sticky;
            int e;
            int s;
            ns = '0;
            ex = bits[62:52];
            if (ex == 11'h7FF) return 1'b0;
            if (bits[63]) return (ex == 0 && bits[51:0] == 0);
            if (ex == 0) begin
                m = {1'b0, bits[51:0]};
                e = -1074;
            end
            else begin
                m = {1'b1, bits[51:0]};
                e = int'(ex) - 1075;
            end
            if (m == 0) return 1'b1;
            q = {75'b0, m} * 128'd1000000000;
            if (e >= 0) begin
                if (q[127:64] != 0 || e >= 64) return 1'b0;
                wide = {64'b0, q} << e;
                if (wide[191:64] != 0) return 1'b0;
                ns = wide[63:0];
                return 1'b1;
            end
            s = -e;
            if (s >= 128) return 1'b1;
            f = q >> s;
            rb = q[s-1];
            sticky = q & ((128'd1 << s) - 128'd1);
            if (f[127:64] != 0) return 1'b0;
            if (f[63:0] == 64'hFFFF_FFFF_FFFF_FFFF && (rb || sticky != 0)) return 1'b0;
            ns = f[63:0] + 64'(rb);
            return 1'b1;
        endfunction

        function automatic void set_register(input logic idx, input logic [63:0] value);
            if (idx == lpv_pkg::CFG_TIME_OFFSET) offset_ns = value;
            else max_delta = value;
        endfunction

        function automatic void note_request(input logic op,
                                             input logic [lpv_pkg::IN_DATA_W-1:0] d);
            point_result_t r;
            logic [63:0] adj;
            logic [63:0] pns;
            logic [63:0] gap_ns;
            logic [15:0] ring;
            bit valid;
            bit ring_ok;
            r = '{default: '0};
            if (op == lpv_pkg::OP_HEADER) begin
                have_prev = 1'b0;
                prev_ring = '0;
                group_count = '0;
                rejected = '0;
                if (d[31] || d[63:32] >= 32'd1000000000) begin
                    header_ns = '0;
                    r.status = lpv_pkg::STATUS_BAD_STAMP;
                end
                else begin
                    header_ns = 64'(d[30:0]) * 64'd1000000000 + 64'(d[63:32]);
                    if (add_offset(header_ns, adj)) r.stamp_ns = adj;
                    else r.status = lpv_pkg::STATUS_OFFSET;
                end
            end
            else begin
                ring = d[79:64];
                ring_ok = ring < 16'd16;
                if (ring_ok) begin
                    if (have_prev && ring <= 16'(prev_ring) && group_count != '1)
                        group_count++;
                    prev_ring = ring[7:0];
                    have_prev = 1'b1;
                end
                valid = ring_ok && d[110:103] != 8'hFF && d[142:135] != 8'hFF &&
                        d[174:167] != 8'hFF && d[206:199] != 8'hFF &&
                        seconds_to_ns(d[271:208], pns) && pns != 0;
                if (valid) begin
                    gap_ns = pns >= header_ns ? pns - header_ns : header_ns - pns;
                    valid = gap_ns <= max_delta && add_offset(pns, adj);
                end
                if (!valid) begin
                    if (rejected != '1) rejected++;
                    r.status = lpv_pkg::STATUS_INVALID;
                end
                else r.stamp_ns = adj;
                r.group_num = group_count;
                r.ring_out = ring;
                r.x_out = d[111:80];
                r.y_out = d[143:112];
                r.z_out = d[175:144];
                r.intensity_out = d[207:176];
                r.invalid_count = rejected;
            end
            pending = {pending, r};
        endfunction

        task automatic check_result(input logic [lpv_pkg::OUT_DATA_W-1:0] t);
            point_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", t[65:2], '0);
                return;
            end
            w = pending.pop_front();
            if (t[1:0] !== w.status) report_mismatch("status", t[1:0], w.status);
            if (t[65:2] !== w.stamp_ns) report_mismatch("stamp_ns", t[65:2], w.stamp_ns);
            if (t[97:66] !== w.group_num)
                report_mismatch("group_num", t[97:66], w.group_num);
            if (t[113:98] !== w.ring_out) report_mismatch("ring_out", t[113:98], w.ring_out);
            if (t[145:114] !== w.x_out) report_mismatch("x_out", t[145:114], w.x_out);
            if (t[177:146] !== w.y_out) report_mismatch("y_out", t[177:146], w.y_out);
            if (t[209:178] !== w.z_out) report_mismatch("z_out", t[209:178], w.z_out);
            if (t[241:210] !== w.intensity_out)
                report_mismatch("intensity_out", t[241:210], w.intensity_out);
            if (t[273:242] !== w.invalid_count)
                report_mismatch("invalid_count", t[273:242], w.invalid_count);
        endtask
    endclass

    stamp_scoreboard sb = new();

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
        if (m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
            results_seen++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_request(input logic op, input logic [lpv_pkg::IN_DATA_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (op == lpv_pkg::OP_HEADER) headers_sent++;
        else points_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [63:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sb.set_register(idx, value);
    endtask

    function automatic logic [lpv_pkg::IN_DATA_W-1:0] header_data(input logic [31:0] sec,
                                                                  input logic [31:0] nsec);
        logic [lpv_pkg::IN_DATA_W-1:0] d;
        d = '0;
        d[31:0] = sec;
        d[63:32] = nsec;
        d[lpv_pkg::IN_DATA_W-1:64] = 208'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom});
        return d;
    endfunction

    function automatic logic [lpv_pkg::IN_DATA_W-1:0] point_data(input logic [15:0] ring,
        input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
        input logic [31:0] inten, input logic [63:0] tbits);
        return {tbits, inten, z, y, x, ring, $urandom, $urandom};
    endfunction

    function automatic logic [31:0] random_single();
        logic [31:0] b;
        b = $urandom;
        if ($urandom_range(0, 19) == 0) b[30:23] = 8'hFF;
        else if (b[30:23] == 8'hFF) b[30:23] = 8'(($urandom_range(0, 253)));
        return b;
    endfunction

    real cur_header_s = 0.0;

    function automatic logic [63:0] random_time();
        int pick;
        logic [63:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            return $realtobits(cur_header_s +
                               (real'($urandom_range(0, 300000)) - 150000.0) * 1.0e-6);
        if (pick < 81) return 64'h8000_0000_0000_0000;
        if (pick < 84) return {12'h000, 20'($urandom), $urandom};
        if (pick < 87) return 64'h7FF0_0000_0000_0000 | 64'($urandom_range(0, 1)) << 51;
        if (pick < 90) return {12'h43F, 20'($urandom), $urandom};
        b = {$urandom, $urandom};
        return b;
    endfunction

    task automatic send_header(input logic [31:0] sec, input logic [31:0] nsec);
        if (!sec[31] && nsec < 32'd1000000000) cur_header_s = real'(sec) + real'(nsec) * 1.0e-9;
        send_request(lpv_pkg::OP_HEADER, header_data(sec, nsec));
    endtask

    task automatic random_phase(input int count, input bit pause_midway);
        int k;
        logic [15:0] ring;
        for (k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) drain_results();
            if ($urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 9) == 0)
                    send_header($urandom, $urandom);
                else
                    send_header($urandom_range(0, 2000000000), $urandom_range(0, 999999999));
            end
            else begin
                ring = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
                send_request(lpv_pkg::OP_POINT, point_data(ring, random_single(),
                             random_single(), random_single(), random_single(),
                             random_time()));
            end
        end
    endtask

    initial
    begin
        logic [63:0] one_s;
        one_s = $realtobits(1.0);
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_register(lpv_pkg::CFG_TIME_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(lpv_pkg::CFG_MAX_DELTA, 64'hFFFF_FFFF_FFFF_FFFF);
        send_header(32'd0, 32'd0);
        send_header(32'h8000_0000, 32'd5);
        send_header(32'd3, 32'd1000000000);
        send_header(32'd1, 32'hFFFF_FFFF);
        send_header(32'h7FFF_FFFF, 32'd999999999);
        send_header(32'd1, 32'd0);
        send_request(lpv_pkg::OP_POINT, point_data(16'd15, 32'h3F80_0000, '0, '0, '0, one_s));
        send_request(lpv_pkg::OP_POINT, point_data(16'd3, 32'hFFFF_FFFF, '0, '0, '0, one_s));
        send_request(lpv_pkg::OP_POINT, point_data(16'd3, '0, 32'h7F80_0000, '0, '0, one_s));
        send_request(lpv_pkg::OP_POINT, point_data(16'd0, '0, '0, 32'h7FC0_0000, '0, one_s));
        send_request(lpv_pkg::OP_POINT, point_data(16'd0, '0, '0, '0, 32'hFF80_0000, one_s));
        send_request(lpv_pkg::OP_POINT, point_data(16'd16, '0, '0, '0, '0, one_s));
        send_request(lpv_pkg::OP_POINT, point_data(16'hFFFF, '1, '1, '1, '1, '1));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd5, '0, '0, '0, '0, 64'h8000_0000_0000_0000));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd6, '0, '0, '0, '0, 64'h0000_0000_0000_0001));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd7, '0, '0, '0, '0, 64'h7FEF_FFFF_FFFF_FFFF));
        send_request(lpv_pkg::OP_POINT, point_data(16'd8, '0, '0, '0, '0, $realtobits(-1.0)));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd9, '0, '0, '0, '0, 64'h7FF0_0000_0000_0000));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd9, '0, '0, '0, '0, $realtobits(1.5e-9)));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd1, '0, '0, '0, '0, $realtobits(18.0e9)));
        send_request(lpv_pkg::OP_POINT,
                     point_data(16'd2, '0, '0, '0, '0, $realtobits(0.5e-9)));
        send_header(32'd2, 32'd500);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_register(lpv_pkg::CFG_TIME_OFFSET, 64'd0);
                    write_register(lpv_pkg::CFG_MAX_DELTA, 64'd100000000);
                end
                1: begin
                    write_register(lpv_pkg::CFG_TIME_OFFSET, 64'h7FFF_FFFF_FFFF_FFFF);
                    write_register(lpv_pkg::CFG_MAX_DELTA, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                2: begin
                    write_register(lpv_pkg::CFG_TIME_OFFSET, 64'h8000_0000_0000_0000);
                    write_register(lpv_pkg::CFG_MAX_DELTA, 64'd0);
                end
                3: begin
                    write_register(lpv_pkg::CFG_TIME_OFFSET, -64'sd1500000000);
                    write_register(lpv_pkg::CFG_MAX_DELTA, 64'd60000000);
                end
                default: begin
                    write_register(lpv_pkg::CFG_TIME_OFFSET,
                                   {$urandom, $urandom} >> $urandom_range(0, 63));
                    write_register(lpv_pkg::CFG_MAX_DELTA, 64'd120000000);
                end
            endcase
            send_idle_pct = (phase < 2) ? 15 : (phase < 4) ? 53 : 0;
            recv_idle_pct = (phase < 2) ? 53 : (phase < 4) ? 15 : 0;
            send_header($urandom_range(0, 2000000000), $urandom_range(0, 999999999));
            random_phase(118, phase == 1);
            drain_results();
        end

        $display("Covered %0d headers and %0d points over six register settings,",
                 headers_sent, points_sent);
        $display("with stalls on both sides and %0d results checked.", results_seen);
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/core/lpv_pkg.sv
rtl/core/lpv_ns_conv.sv
rtl/core/lidar_point_validator_core.sv
dv/lidar_point_validator_core_test.sv
